@@ sv/kdpl_pkg.sv @@
// Types and constants shared by the kd-tree point locate block.
package kdpl_pkg;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 232;
   localparam int RSP_DATA_W = 80;

   localparam int COORD_W   = 32;
   localparam int CHILD_W   = 11;
   localparam int INDEX_W   = 10;
   localparam int PAYLOAD_W = 64;

   // Request kinds carried on req_tuser
   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   // Response status carried on rsp_tuser
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_TREE = 2'd1,
      ST_DEPTH   = 2'd2,
      ST_WRITE   = 2'd3
   } status_type;

   // Split axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   typedef enum logic [1:0] {
      WS_IDLE = 2'd0,
      WS_WALK = 2'd1,
      WS_DONE = 2'd2
   } walk_state_type;

   // One unpacked request
   typedef struct packed {
      opcode_type             opcode;
      logic [INDEX_W-1:0]     node_index;
      logic [1:0]             split_axis;
      logic [COORD_W-1:0]     split_value;
      logic [CHILD_W-1:0]     left_child;
      logic [CHILD_W-1:0]     right_child;
      logic [PAYLOAD_W-1:0]   leaf_payload;
      logic [COORD_W-1:0]     query_x;
      logic [COORD_W-1:0]     query_y;
      logic [COORD_W-1:0]     query_z;
   } req_item_type;

   // One node table entry
   typedef struct packed {
      logic [1:0]             axis;
      logic [COORD_W-1:0]     split;
      logic [CHILD_W-1:0]     left;
      logic [CHILD_W-1:0]     right;
      logic [PAYLOAD_W-1:0]   payload;
   } node_entry_type;

   // One response
   typedef struct packed {
      status_type             status;
      logic [PAYLOAD_W-1:0]   payload;
      logic [INDEX_W-1:0]     node;
   } result_type;

endpackage

@@ sv/kd_tree_point_locate.sv @@
// Top level of the kd-tree point locate block.
//
// Requests arrive on the req_ stream. req_tuser selects a node write or a
// point query. A write stores one node entry and answers with status write
// done; a query walks the table from node 0, one node per cycle, and
// answers with the payload and index of the stopping node or an error.
// Each request gives exactly one response on the rsp_ stream.
// A write, or a query without a loaded root, passes from the sequencer's
// done state into the output register; a query first reads the node table
// once per level, through its registered read port, until it stops.
// One request is worked on at a time; the next one is taken in the cycle
// after the response moves into the output register. A stalled receiver
// only blocks once both the output register and the sequencer hold a
// response.
// Reset clears the sequencer, the output valid and the root-loaded flag;
// the node table is not cleared, and entries must be written before a walk
// reaches them.
module kd_tree_point_locate #(
   parameter int NODE_SLOTS = 1024,
   parameter int MAX_DEPTH  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // opcode
   input  logic                              req_tuser,
   // node_index, split_axis, split_value, left_child, right_child,
   // leaf_payload, query_x, query_y, query_z, zero pad
   input  logic [kdpl_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status
   output logic [1:0]                        rsp_tuser,
   // found_payload, found_node, zero pad
   output logic [kdpl_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import kdpl_pkg::*;

   localparam int ADDR_W = $clog2(NODE_SLOTS);

   req_item_type   req;
   result_type     res;
   logic           res_valid, res_ready;
   logic           mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   node_entry_type mem_wr_data, mem_rd_data;

   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_ff;

   // Unpack request
   assign req.opcode       = opcode_type'(req_tuser);
   assign req.node_index   = req_tdata[9:0];
   assign req.split_axis   = req_tdata[11:10];
   assign req.split_value  = req_tdata[43:12];
   assign req.left_child   = req_tdata[54:44];
   assign req.right_child  = req_tdata[65:55];
   assign req.leaf_payload = req_tdata[129:66];
   assign req.query_x      = req_tdata[161:130];
   assign req.query_y      = req_tdata[193:162];
   assign req.query_z      = req_tdata[225:194];

   kdpl_walk #(
      .NODE_SLOTS (NODE_SLOTS),
      .MAX_DEPTH  (MAX_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   kdpl_node_ram #(
      .NODE_SLOTS (NODE_SLOTS),
      .ADDR_W     (ADDR_W)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: loads when empty or being drained
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {(RSP_DATA_W - PAYLOAD_W - INDEX_W)'(0), rsp_ff.node, rsp_ff.payload};

endmodule

@@ sv/kdpl_node_ram.sv @@
// Node table memory: one write port, one read port, registered read data.
module kdpl_node_ram #(
   parameter int NODE_SLOTS = 1024,
   parameter int ADDR_W     = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  kdpl_pkg::node_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output kdpl_pkg::node_entry_type rd_data
);
   import kdpl_pkg::*;

   node_entry_type node_mem_ff [NODE_SLOTS];
   node_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= node_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/kdpl_walk.sv @@
// Request sequencer: node writes and the level-by-level tree walk.
module kdpl_walk #(
   parameter int NODE_SLOTS = 1024,
   parameter int MAX_DEPTH  = 16,
   parameter int ADDR_W     = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  kdpl_pkg::req_item_type   req,
   output logic                     res_valid,
   input  logic                     res_ready,
   output kdpl_pkg::result_type     res,
   output logic                     mem_wr_en,
   output logic [ADDR_W-1:0]        mem_wr_addr,
   output kdpl_pkg::node_entry_type mem_wr_data,
   output logic                     mem_rd_en,
   output logic [ADDR_W-1:0]        mem_rd_addr,
   input  kdpl_pkg::node_entry_type mem_rd_data
);
   import kdpl_pkg::*;

   localparam int RD_W  = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W = 17;

   walk_state_type       state_ff, state_in;
   logic [INDEX_W-1:0]   cur_ff, cur_in;
   logic [RD_W-1:0]      reads_ff, reads_in;
   logic [COORD_W-1:0]   qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic                 root_loaded_ff, root_loaded_in;
   result_type           res_ff, res_in;

   logic [COORD_W-1:0]   coord;
   logic [COORD_W:0]     diff;
   logic [CHILD_W-1:0]   child;
   logic                 child_none;
   logic                 slot_ok;

   // Node compare on the entry just read
   always_comb begin
      unique case (mem_rd_data.axis)
         AXIS_X:  coord = qx_ff;
         AXIS_Y:  coord = qy_ff;
         default: coord = qz_ff;
      endcase
      diff = {coord[COORD_W-1], coord}
           - {mem_rd_data.split[COORD_W-1], mem_rd_data.split};
      child = diff[COORD_W] ? mem_rd_data.left : mem_rd_data.right;
      child_none = child[CHILD_W-1]
                 || ({(CMP_W - INDEX_W)'(0), child[INDEX_W-1:0]} >= CMP_W'(NODE_SLOTS));
      slot_ok = {(CMP_W - INDEX_W)'(0), req.node_index} < CMP_W'(NODE_SLOTS);
   end

   // Next state and memory control
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      reads_in       = reads_ff;
      qx_in          = qx_ff;
      qy_in          = qy_ff;
      qz_in          = qz_ff;
      root_loaded_in = root_loaded_ff;
      res_in         = res_ff;
      req_ready      = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = ADDR_W'(req.node_index);
      mem_wr_data    = '{axis: req.split_axis, split: req.split_value,
                         left: req.left_child, right: req.right_child,
                         payload: req.leaf_payload};
      mem_rd_en      = 1'b0;
      mem_rd_addr    = '0;
      unique case (state_ff)
         WS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req.opcode == OP_WRITE) begin
                  mem_wr_en = slot_ok;
                  if (slot_ok && (req.node_index == '0)) begin
                     root_loaded_in = 1'b1;
                  end
                  res_in   = '{status: ST_WRITE, payload: '0, node: req.node_index};
                  state_in = WS_DONE;
               end else if (!root_loaded_ff) begin
                  res_in   = '{status: ST_NO_TREE, payload: '0, node: '0};
                  state_in = WS_DONE;
               end else begin
                  // Start at the root
                  qx_in     = req.query_x;
                  qy_in     = req.query_y;
                  qz_in     = req.query_z;
                  cur_in    = '0;
                  reads_in  = '0;
                  mem_rd_en = 1'b1;
                  state_in  = WS_WALK;
               end
            end
         end
         WS_WALK: begin
            if (child_none) begin
               res_in   = '{status: ST_OK, payload: mem_rd_data.payload, node: cur_ff};
               state_in = WS_DONE;
            end else if (reads_ff == RD_W'(MAX_DEPTH)) begin
               res_in   = '{status: ST_DEPTH, payload: '0, node: cur_ff};
               state_in = WS_DONE;
            end else begin
               // Descend one level
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'(child[INDEX_W-1:0]);
               cur_in      = child[INDEX_W-1:0];
               reads_in    = reads_ff + RD_W'(1);
            end
         end
         WS_DONE: begin
            if (res_ready) begin
               state_in = WS_IDLE;
            end
         end
         default: state_in = WS_IDLE;
      endcase
   end

   assign res_valid = (state_ff == WS_DONE);
   assign res       = res_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= WS_IDLE;
         root_loaded_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         root_loaded_ff <= root_loaded_in;
      end
   end

   // Walk context and result
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      reads_ff <= reads_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      qz_ff    <= qz_in;
      res_ff   <= res_in;
   end

   // Reads and writes never share a cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("node table read and write in one cycle");

   // Query before the root is loaded answers at once
   a_no_tree: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req.opcode == OP_QUERY) && !root_loaded_ff)
      |=> (res_valid && (res.status == ST_NO_TREE)))
      else $error("missing no-tree response");

   // Walk never goes past the depth limit
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WS_WALK) |-> (reads_ff <= RD_W'(MAX_DEPTH)))
      else $error("walk depth beyond limit");

   // Staying in the walk always comes with the next node read
   a_walk_reads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == WS_WALK) && (state_in == WS_WALK)) |-> mem_rd_en)
      else $error("walk step without node read");

endmodule

@@ bench/point_locate_checker.sv @@
// Response checker for the kd-tree point locate block: predicts each response and compares.
module point_locate_checker
   import kdpl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [1:0]            rsp_tuser,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatches,
   output int                    outstanding
);

   localparam int TABLE_SLOTS = 1024;
   localparam int WALK_LIMIT  = 16;

   // Shadow copy of the node table and root flag
   node_entry_type node_table [TABLE_SLOTS];
   logic           root_loaded = 1'b0;
   result_type     pending_results [$];
   int             fail_count = 0;

   // Walk from node 0 the way the block should, one node per level
   function automatic result_type walk_tree(input logic [COORD_W-1:0] qx,
                                            input logic [COORD_W-1:0] qy,
                                            input logic [COORD_W-1:0] qz);
      result_type         res;
      node_entry_type     entry;
      logic [COORD_W-1:0] coord;
      logic [CHILD_W-1:0] child;
      int                 cur;
      int                 reads;
      cur = 0;
      for (reads = 0; reads <= WALK_LIMIT; reads++) begin
         entry = node_table[cur];
         case (entry.axis)
            AXIS_X:  coord = qx;
            AXIS_Y:  coord = qy;
            default: coord = qz;   // selector two and three both pick z
         endcase
         // only the sign of coord - split matters, so a signed compare is exact
         child = ($signed(coord) < $signed(entry.split)) ? entry.left : entry.right;
         // negative or out-of-table child means none
         if (child[CHILD_W-1] || int'(child) >= TABLE_SLOTS) begin
            res.status  = ST_OK;
            res.payload = entry.payload;
            res.node    = INDEX_W'(cur);
            return res;
         end
         if (reads == WALK_LIMIT)
            break;
         cur = int'(child);
      end
      res.status  = ST_DEPTH;
      res.payload = '0;
      res.node    = INDEX_W'(cur);
      return res;
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      result_type          want;
      result_type          got;
      logic [INDEX_W-1:0]  idx;
      if (reset) begin
         root_loaded = 1'b0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status  = status_type'(rsp_tuser);
            got.payload = rsp_tdata[63:0];
            got.node    = rsp_tdata[73:64];
            if (pending_results.size() == 0) begin
               $display({"%0t: unexpected response, expected none actual status %0d",
                         " payload %h node %0d"},
                        $time, got.status, got.payload, got.node);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
               if (got.payload !== want.payload) begin
                  $display("%0t: payload expected %h actual %h",
                           $time, want.payload, got.payload);
                  fail_count++;
               end
               if (got.node !== want.node) begin
                  $display("%0t: node expected %0d actual %0d",
                           $time, want.node, got.node);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            idx = req_tdata[9:0];
            if (opcode_type'(req_tuser) == OP_WRITE) begin
               if (int'(idx) < TABLE_SLOTS) begin
                  node_table[idx].axis    = req_tdata[11:10];
                  node_table[idx].split   = req_tdata[43:12];
                  node_table[idx].left    = req_tdata[54:44];
                  node_table[idx].right   = req_tdata[65:55];
                  node_table[idx].payload = req_tdata[129:66];
                  if (idx == '0)
                     root_loaded = 1'b1;
               end
               want.status  = ST_WRITE;
               want.payload = '0;
               want.node    = idx;
            end else if (!root_loaded) begin
               want.status  = ST_NO_TREE;
               want.payload = '0;
               want.node    = '0;
            end else begin
               want = walk_tree(req_tdata[161:130], req_tdata[193:162], req_tdata[225:194]);
            end
            pending_results = {pending_results, want};
         end
      end
      mismatches  <= fail_count;
      outstanding <= pending_results.size();
   end

endmodule

@@ bench/testbench.sv @@
// Testbench top for the kd-tree point locate block: request stimulus, response pacing, verdict.
module testbench;
   import kdpl_pkg::*;

   localparam int                 REQUEST_COUNT = 1650;
   localparam int                 LAST_SLOT     = 1023;
   localparam logic [CHILD_W-1:0] NO_CHILD      = '1;
   localparam logic [COORD_W-1:0] COORD_MIN     = 32'h8000_0000;
   localparam logic [COORD_W-1:0] COORD_MAX     = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_NEG1    = 32'hFFFF_FFFF;
   localparam logic [1:0]         AXIS_Z        = 2'd2;
   localparam logic [1:0]         AXIS_Z_ALT    = 2'd3;
   localparam int                 LONG_HOLD     = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    mismatches;
   int                    outstanding;

   // Stimulus-side bookkeeping: which slots hold a node, and their splits
   int                    sent_count = 0;
   bit                    sender_fast = 1'b0;
   bit                    node_written [LAST_SLOT+1];
   int                    written_slots [$];
   logic [COORD_W-1:0]    split_at [LAST_SLOT+1];

   always #4 clock = ~clock;

   kd_tree_point_locate i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   point_locate_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // tdata layout, lowest bit first
   function automatic logic [REQ_DATA_W-1:0] pack_request(input req_item_type it);
      logic [REQ_DATA_W-1:0] d;
      d          = '0;
      d[9:0]     = it.node_index;
      d[11:10]   = it.split_axis;
      d[43:12]   = it.split_value;
      d[54:44]   = it.left_child;
      d[65:55]   = it.right_child;
      d[129:66]  = it.leaf_payload;
      d[161:130] = it.query_x;
      d[193:162] = it.query_y;
      d[225:194] = it.query_z;
      return d;
   endfunction

   // Unused fields of a request carry random junk
   function automatic req_item_type random_item();
      req_item_type it;
      it.opcode       = opcode_type'($urandom_range(0, 1));
      it.node_index   = INDEX_W'($urandom);
      it.split_axis   = 2'($urandom);
      it.split_value  = $urandom;
      it.left_child   = CHILD_W'($urandom);
      it.right_child  = CHILD_W'($urandom);
      it.leaf_payload = {$urandom, $urandom};
      it.query_x      = $urandom;
      it.query_y      = $urandom;
      it.query_z      = $urandom;
      return it;
   endfunction

   function automatic req_item_type make_query(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [COORD_W-1:0] z);
      req_item_type it;
      it         = random_item();
      it.opcode  = OP_QUERY;
      it.query_x = x;
      it.query_y = y;
      it.query_z = z;
      return it;
   endfunction

   function automatic logic [CHILD_W-1:0] none_child();
      return $urandom_range(0, 1) ? NO_CHILD : CHILD_W'($urandom_range(1024, 2047));
   endfunction

   // Child from a pool of written slots; chain mode favors the newest
   function automatic logic [CHILD_W-1:0] pick_child(input int pool[$], input bit chain);
      int r;
      r = $urandom_range(0, 9);
      if (pool.size() == 0)
         return none_child();
      if (chain)
         return (r < 8) ? CHILD_W'(pool[pool.size()-1]) : none_child();
      if (r < 3)
         return none_child();
      if (r < 7)
         return CHILD_W'(pool[pool.size()-1]);
      return CHILD_W'(pool[$urandom_range(0, pool.size()-1)]);
   endfunction

   function automatic logic [COORD_W-1:0] random_split();
      case ($urandom_range(0, 7))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Query coordinate: random, extreme, or within one of a stored split
   function automatic logic [COORD_W-1:0] random_coord();
      int r;
      int slot;
      r = $urandom_range(0, 9);
      if (r < 4 || written_slots.size() == 0)
         return $urandom;
      if (r == 4) begin
         case ($urandom_range(0, 3))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return COORD_NEG1;
         endcase
      end
      slot = written_slots[$urandom_range(0, written_slots.size()-1)];
      return split_at[slot] + COORD_W'($urandom_range(0, 2)) - 32'd1;
   endfunction

   // One request through the handshake, after a random gap unless the sender is fast
   task automatic send_request(input req_item_type it);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.opcode;
      req_tdata  <= pack_request(it);
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sent_count++;
   endtask

   // Node write; the caller keeps children on written slots or none
   task automatic put_node(input int idx, input logic [1:0] axis,
                           input logic [COORD_W-1:0] split,
                           input logic [CHILD_W-1:0] left,
                           input logic [CHILD_W-1:0] right,
                           input logic [PAYLOAD_W-1:0] payload);
      req_item_type it;
      it              = random_item();
      it.opcode       = OP_WRITE;
      it.node_index   = INDEX_W'(idx);
      it.split_axis   = axis;
      it.split_value  = split;
      it.left_child   = left;
      it.right_child  = right;
      it.leaf_payload = payload;
      send_request(it);
      if (!node_written[idx])
         written_slots = {written_slots, idx};
      node_written[idx] = 1'b1;
      split_at[idx]     = split;
   endtask

   // Hold requests until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic run_queries(input int count);
      repeat (count) send_request(make_query(random_coord(), random_coord(), random_coord()));
   endtask

   // Build a subtree bottom-up, hang it under node 0, then query it
   task automatic grow_tree();
      int build[$];
      int n;
      int slot;
      bit chain;
      chain = ($urandom_range(0, 3) == 0);
      n     = chain ? $urandom_range(13, 19) : $urandom_range(1, 20);
      repeat (n) begin
         slot = $urandom_range(1, LAST_SLOT);
         put_node(slot, 2'($urandom), random_split(), pick_child(build, chain),
                  pick_child(build, chain), {$urandom, $urandom});
         build = {build, slot};
      end
      put_node(0, 2'($urandom), random_split(), pick_child(build, chain),
               pick_child(build, chain), {$urandom, $urandom});
      run_queries($urandom_range(3, 12));
   endtask

   // Response side: random stalls, fast stretches, one long hold-off
   initial begin
      int gap;
      int taken;
      bit fast;
      taken = 0;
      fast  = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 19) == 0)
            fast = !fast;
         gap = fast ? 0 : $urandom_range(0, 12);
         if (taken == 400)
            gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   // Request side
   initial begin
      int kind;
      int slot;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: queries without a root, extremes, axis three, odd none values
      send_request(make_query(COORD_MAX, COORD_MIN, '0));
      put_node(5, AXIS_X, COORD_MIN, NO_CHILD, NO_CHILD, 64'hFFFF_FFFF_FFFF_FFFF);
      put_node(LAST_SLOT, AXIS_Z_ALT, COORD_MAX, 11'h400, 11'h7FE, 64'h0);
      send_request(make_query('0, '0, '0));
      put_node(0, AXIS_Y, '0, 11'd5, 11'd1023, 64'h0123_4567_89AB_CDEF);
      send_request(make_query($urandom, COORD_NEG1, $urandom));
      send_request(make_query(COORD_MIN, COORD_MIN, COORD_MIN));
      send_request(make_query($urandom, '0, COORD_MAX));
      send_request(make_query($urandom, COORD_MAX, COORD_MAX - 32'd1));
      send_request(make_query(COORD_MAX, '0, COORD_MIN));
      // Self loop under the root: walk runs until the depth limit
      put_node(7, AXIS_Z, 32'h0001_0000, 11'd7, 11'd7, {$urandom, $urandom});
      put_node(0, AXIS_X, '0, 11'd7, NO_CHILD, 64'hA5A5_5A5A_0F0F_F0F0);
      send_request(make_query(COORD_NEG1, $urandom, $urandom));
      send_request(make_query(COORD_MIN, $urandom, COORD_MAX));
      send_request(make_query('0, $urandom, $urandom));
      send_request(make_query(COORD_MAX, $urandom, $urandom));
      drain();

      // Random: mostly well-formed trees, some stray writes and loose queries
      while (sent_count < REQUEST_COUNT) begin
         sender_fast = ($urandom_range(0, 3) == 0);
         kind        = $urandom_range(0, 19);
         if (kind < 14) begin
            grow_tree();
         end else if (kind < 17) begin
            repeat ($urandom_range(1, 4)) begin
               slot = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, LAST_SLOT);
               put_node(slot, 2'($urandom), random_split(), pick_child(written_slots, 1'b0),
                        pick_child(written_slots, 1'b0), {$urandom, $urandom});
            end
         end else begin
            run_queries($urandom_range(1, 6));
         end
         if ($urandom_range(0, 11) == 0)
            drain();
      end

      // Wait out the last responses, then a margin past the longest walk
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
